FILE: rtl/core/kvrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvrt_pkg
// Shared types and constants for the key/value registry table.
// ----------------------------------------------------------------------------
package kvrt_pkg;

    localparam int KEY_W  = 64;
    localparam int VAL_W  = 64;
    localparam int REQ_W  = 2;
    localparam int FILL_W = 9;

    // request codes; code 3 is a no-op
    localparam logic [REQ_W-1:0] REQ_REGISTER = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOOKUP   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR    = 2'd2;

    localparam logic signed [VAL_W-1:0] MISS_VALUE = '1;

    // controller -> datapath
    typedef struct packed {
        logic load;    // latch request on accept
        logic scan;    // scan in progress
        logic finish;  // commit result and table update
    } kvrt_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hit;       // compared entry matches the key
        logic scan_end;  // no entry left to compare, nothing in flight
    } kvrt_sts_t;

endpackage

FILE: rtl/core/kvrt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvrt_ctrl
// Sequencer: idle / scan, issues load, scan and finish to the datapath.
// ----------------------------------------------------------------------------
module kvrt_ctrl
    import kvrt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  kvrt_sts_t sts,
    output kvrt_cmd_t cmd,
    output logic      busy,
    output logic      done
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.hit || sts.scan_end)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        done_next = cmd.finish;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

FILE: rtl/core/kvrt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvrt_dp
// Datapath: key and value memories, fill count, pipelined linear scan,
// result registers.
// ----------------------------------------------------------------------------
module kvrt_dp
    import kvrt_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  kvrt_cmd_t               cmd,
    output kvrt_sts_t               sts,
    input  logic [REQ_W-1:0]        req_type,
    input  logic [KEY_W-1:0]        actor_key,
    input  logic signed [VAL_W-1:0] session_value,
    output logic                    found,
    output logic signed [VAL_W-1:0] value_out,
    output logic                    dropped,
    output logic [FILL_W-1:0]       fill_count
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [KEY_W-1:0] key_mem [CAPACITY];
    logic [VAL_W-1:0] val_mem [CAPACITY];

    // latched request
    logic [REQ_W-1:0]        req_reg;
    logic [KEY_W-1:0]        key_reg;
    logic signed [VAL_W-1:0] val_reg;

    // scan pipeline
    logic [CNT_W-1:0] issue_idx_reg, issue_idx_next;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [KEY_W-1:0] key_rd_reg;
    logic [VAL_W-1:0] val_rd_reg;

    logic [CNT_W-1:0] count_reg, count_next;

    logic                    found_reg, found_next;
    logic signed [VAL_W-1:0] value_out_reg, value_out_next;
    logic                    dropped_reg, dropped_next;

    logic             search;
    logic             more;
    logic             issue;
    logic             hit_now;
    logic             key_we;
    logic             val_we;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;

    assign search  = (req_reg == REQ_REGISTER) || (req_reg == REQ_LOOKUP);
    assign more    = search && (issue_idx_reg < count_reg);
    assign hit_now = rd_vld_reg && (key_rd_reg == key_reg);
    assign issue   = cmd.scan && more && !hit_now;
    assign rd_addr = issue_idx_reg[IDX_W-1:0];

    assign sts.hit      = hit_now;
    assign sts.scan_end = !more && !rd_vld_reg;

    always_comb
    begin
        issue_idx_next = issue_idx_reg;
        if (cmd.load)
            issue_idx_next = '0;
        else if (issue)
            issue_idx_next = issue_idx_reg + CNT_W'(1);
    end

    // outcome of the request, committed on finish
    always_comb
    begin
        count_next     = count_reg;
        found_next     = 1'b0;
        value_out_next = MISS_VALUE;
        dropped_next   = 1'b0;
        key_we         = 1'b0;
        val_we         = 1'b0;
        wr_addr        = count_reg[IDX_W-1:0];
        if (cmd.finish)
        begin
            priority if (req_reg == REQ_REGISTER)
            begin
                if (hit_now)
                begin
                    found_next = 1'b1;
                    val_we     = 1'b1;
                    wr_addr    = rd_idx_reg;
                end
                else if (count_reg < CAP_CNT)
                begin
                    key_we     = 1'b1;
                    val_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
                else
                begin
                    dropped_next = 1'b1;
                end
            end
            else if (req_reg == REQ_LOOKUP)
            begin
                if (hit_now)
                begin
                    found_next     = 1'b1;
                    value_out_next = val_rd_reg;
                end
            end
            else if (req_reg == REQ_CLEAR)
            begin
                count_next = '0;
            end
            else
            begin
                count_next = count_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[wr_addr] <= key_reg;
        if (val_we)
            val_mem[wr_addr] <= val_reg;
        key_rd_reg <= key_mem[rd_addr];
        val_rd_reg <= val_mem[rd_addr];
        rd_idx_reg <= rd_addr;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_type;
            key_reg <= actor_key;
            val_reg <= session_value;
        end
        if (cmd.finish)
        begin
            found_reg     <= found_next;
            value_out_reg <= value_out_next;
            dropped_reg   <= dropped_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_idx_reg <= '0;
            rd_vld_reg    <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            issue_idx_reg <= issue_idx_next;
            rd_vld_reg    <= issue;
            count_reg     <= count_next;
        end
    end

    assign found      = found_reg;
    assign value_out  = value_out_reg;
    assign dropped    = dropped_reg;
    // count only moves on finish, so it is stable while the result is shown
    assign fill_count = FILL_W'(count_reg);

endmodule

FILE: rtl/core/key_value_registry_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_registry_table_unit
// Bounded key/value table filled in arrival order, searched by linear scan.
// ----------------------------------------------------------------------------
// A search ends at the first hit, or once every filled entry has been compared
//   and no read is left in flight; clear and no-op finish without reading the
//   table.
// Throughput: one request at a time; the scan reads one entry per cycle from
//   the single read port of the key/value memories.
// start is taken again in the cycle done is shown; the receiver cannot stall.
// Reset clears the fill count and the sequencer; the memories are not swept.
// ----------------------------------------------------------------------------
module key_value_registry_table_unit
    import kvrt_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // request beat
    input  logic                    start,
    output logic                    busy,
    input  logic [REQ_W-1:0]        req_type,
    input  logic [KEY_W-1:0]        actor_key,
    input  logic signed [VAL_W-1:0] session_value,
    // result beat, one cycle per request
    output logic                    done,
    output logic                    found,
    output logic signed [VAL_W-1:0] value_out,
    output logic                    dropped,
    output logic [FILL_W-1:0]       fill_count
);

    kvrt_cmd_t cmd;
    kvrt_sts_t sts;

    // Sequencer: IDLE takes a beat, SCAN runs until the compare stage hits
    // or the scan runs past the fill count, then commits and returns.
    kvrt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Datapath: the scan issues one read a cycle; the compare sits one stage
    // behind on the registered read data.  A register hit rewrites the value
    // at the matching index, a miss appends at the fill count if there is
    // room, else the beat is flagged as dropped.  Clear only zeroes the count,
    // so stale entries are never read again.
    kvrt_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .req_type      (req_type),
        .actor_key     (actor_key),
        .session_value (session_value),
        .found         (found),
        .value_out     (value_out),
        .dropped       (dropped),
        .fill_count    (fill_count)
    );

endmodule

FILE: rtl/core/kvrt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvrt_checker
// Port-level checks for the key/value registry table, bound to the top.
// ----------------------------------------------------------------------------
module kvrt_checker
    import kvrt_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    done,
    input logic                    found,
    input logic signed [VAL_W-1:0] value_out,
    input logic                    dropped
);

    // an accepted beat always occupies the unit
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    // a result never shows while a request is in work
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // each request finishes with exactly one result beat
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy fell without a result");

    a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat repeated");

    // a dropped register is a miss and returns the miss value
    a_drop_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (done && dropped) |-> (!found && (value_out == MISS_VALUE)))
        else $error("dropped beat reports a hit");

endmodule

bind key_value_registry_table_unit kvrt_checker u_kvrt_checker (.*);

FILE: tb/tb_key_value_registry_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_value_registry_table_unit
// Self-checking bench for the key/value registry table. A driver offers
// request beats from a backlog queue with random gaps. A scoreboard model of
// the table predicts each result at the accept edge. A monitor checks every
// done beat against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_key_value_registry_table_unit;
    import kvrt_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int HOT_N       = 26;
    // code 3 has no name in the package; the block treats it as a no-op
    localparam logic [REQ_W-1:0] REQ_NOP = 2'd3;
    // slowest request is a full miss scan over all TABLE_DEPTH entries; allow for
    // sender gaps and then take the whole thing four times over
    localparam int unsigned CYCLE_LIMIT = 4 * 1600 * (TABLE_DEPTH + 3 + 24);

    typedef struct packed {
        logic [REQ_W-1:0]        kind;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] val;
    } req_beat_t;

    typedef struct packed {
        logic                    found;
        logic signed [VAL_W-1:0] value;
        logic                    dropped;
        logic [FILL_W-1:0]       fill;
    } kv_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [REQ_W-1:0]        req_type = REQ_NOP;
    logic [KEY_W-1:0]        actor_key = '0;
    logic signed [VAL_W-1:0] session_value = '0;
    logic                    done;
    logic                    found;
    logic signed [VAL_W-1:0] value_out;
    logic                    dropped;
    logic [FILL_W-1:0]       fill_count;

    // Stimulus backlog and predicted results still to arrive
    req_beat_t  req_backlog[$];
    kv_result_t result_due[$];

    // Scoreboard copy of the table
    logic [KEY_W-1:0]        key_mem[TABLE_DEPTH];
    logic signed [VAL_W-1:0] val_mem[TABLE_DEPTH];
    int                      n_entries = 0;

    // Key pools for the random part
    logic [KEY_W-1:0] hot_keys[HOT_N];
    logic [KEY_W-1:0] fill_keys[TABLE_DEPTH];
    bit               fill_ready = 1'b0;

    int          beats_taken = 0;
    int          mismatches = 0;
    int unsigned cycle_cnt = 0;

    key_value_registry_table_unit #(
        .CAPACITY(TABLE_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req_type(req_type),
        .actor_key(actor_key),
        .session_value(session_value),
        .done(done),
        .found(found),
        .value_out(value_out),
        .dropped(dropped),
        .fill_count(fill_count)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Table model: applies one accepted request and returns what the block
    // should report. Search stops at the first match in arrival order, and
    // only entries below the fill count are ever looked at.
    // ------------------------------------------------------------------------
    function automatic kv_result_t apply_request(req_beat_t rq);
        kv_result_t r;
        int         hit;
        r.found   = 1'b0;
        r.value   = MISS_VALUE;
        r.dropped = 1'b0;
        hit       = -1;
        if (rq.kind == REQ_REGISTER || rq.kind == REQ_LOOKUP)
        begin
            for (int i = 0; i < n_entries; i++)
            begin
                if (hit < 0 && key_mem[i] == rq.key)
                    hit = i;
            end
        end
        if (rq.kind == REQ_REGISTER)
        begin
            if (hit >= 0)
            begin
                val_mem[hit] = rq.val;
                r.found      = 1'b1;
            end
            else if (n_entries < TABLE_DEPTH)
            begin
                key_mem[n_entries] = rq.key;
                val_mem[n_entries] = rq.val;
                n_entries++;
            end
            else
                r.dropped = 1'b1;   // miss on a full table: nothing changes
        end
        else if (rq.kind == REQ_LOOKUP)
        begin
            if (hit >= 0)
            begin
                r.value = val_mem[hit];
                r.found = 1'b1;
            end
        end
        else if (rq.kind == REQ_CLEAR)
            n_entries = 0;          // entries stay in memory but drop out of reach
        r.fill = FILL_W'(n_entries);
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic queue_req(logic [REQ_W-1:0] kind, logic [KEY_W-1:0] key,
                             logic signed [VAL_W-1:0] val);
        req_backlog.push_back('{kind: kind, key: key, val: val});
    endtask

    // Random mix over a small key pool so that hits, updates and refills after
    // a clear are common; a share of fresh keys and no-op codes acts as noise.
    task automatic mixed_burst(int n);
        int               pick;
        logic [KEY_W-1:0] k;
        logic [REQ_W-1:0] kind;
        for (int j = 0; j < n; j++)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
                k = hot_keys[$urandom_range(HOT_N - 1)];
            else if (pick < 85 && fill_ready)
                k = fill_keys[$urandom_range(TABLE_DEPTH - 1)];
            else
                k = rand64();
            pick = $urandom_range(99);
            if (pick < 42)
                kind = REQ_REGISTER;
            else if (pick < 90)
                kind = REQ_LOOKUP;
            else if (pick < 96)
                kind = REQ_CLEAR;
            else
                kind = REQ_NOP;
            queue_req(kind, k, rand64());
        end
    endtask

    // Clear, fill every slot with fresh keys, then work the full table:
    // drops on new keys, updates in place, hits at both ends and misses.
    task automatic fill_to_capacity();
        queue_req(REQ_CLEAR, rand64(), rand64());
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            fill_keys[i] = rand64();
            queue_req(REQ_REGISTER, fill_keys[i], rand64());
        end
        fill_ready = 1'b1;
        queue_req(REQ_LOOKUP, fill_keys[TABLE_DEPTH - 1], rand64());
        queue_req(REQ_LOOKUP, fill_keys[0], rand64());
        for (int j = 0; j < 32; j++)
        begin
            case ($urandom_range(3))
                0: queue_req(REQ_REGISTER, rand64(), rand64());
                1: queue_req(REQ_LOOKUP, fill_keys[$urandom_range(TABLE_DEPTH - 1)],
                             rand64());
                2: queue_req(REQ_REGISTER, fill_keys[$urandom_range(TABLE_DEPTH - 1)],
                             rand64());
                default: queue_req(REQ_LOOKUP, rand64(), rand64());
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver. A beat is taken at an edge with start high and busy low; the
    // model is run on it there. start may drop while the block is busy, so
    // gaps land on every phase of a scan. A stretch of beats runs gap-free.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_blk
        bit offer;
        bit quiet;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                result_due.push_back(apply_request(req_backlog.pop_front()));
                beats_taken++;
            end
            quiet = (beats_taken >= 600 && beats_taken < 800);
            offer = (req_backlog.size() != 0) && (quiet || $urandom_range(99) >= 32);
            start <= offer;
            if (offer)
            begin
                req_type      <= req_backlog[0].kind;
                actor_key     <= req_backlog[0].key;
                session_value <= req_backlog[0].val;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. done lasts one cycle and cannot be held off, so every done
    // edge must meet a waiting prediction.
    // ------------------------------------------------------------------------
    task automatic flag_result(string tag, kv_result_t want, kv_result_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $write("%s: want found=%0b value=%0d dropped=%0b fill=%0d",
                   tag, want.found, want.value, want.dropped, want.fill);
            $display(" | got found=%0b value=%0d dropped=%0b fill=%0d",
                     got.found, got.value, got.dropped, got.fill);
        end
    endtask

    always @(posedge clk)
    begin : check_blk
        kv_result_t got;
        kv_result_t want;
        if (rst_n && done)
        begin
            got = '{found: found, value: value_out, dropped: dropped, fill: fill_count};
            if (result_due.size() == 0)
                flag_result("unexpected result", '0, got);
            else
            begin
                want = result_due.pop_front();
                if (got.found !== want.found || got.value !== want.value ||
                    got.dropped !== want.dropped || got.fill !== want.fill)
                    flag_result("mismatch", want, got);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        hot_keys[0] = '0;
        hot_keys[1] = '1;
        for (int i = 2; i < HOT_N; i++)
            hot_keys[i] = rand64();

        // directed: empty table, key and value extremes, update in place,
        // miss, no-op code, clear with a stale entry behind it, clear on empty
        queue_req(REQ_LOOKUP, '0, '0);
        queue_req(REQ_REGISTER, '0, {1'b1, {(VAL_W - 1){1'b0}}});
        queue_req(REQ_REGISTER, '1, {1'b0, {(VAL_W - 1){1'b1}}});
        queue_req(REQ_LOOKUP, '0, rand64());
        queue_req(REQ_LOOKUP, '1, rand64());
        queue_req(REQ_REGISTER, '0, MISS_VALUE);
        queue_req(REQ_LOOKUP, '0, rand64());
        queue_req(REQ_LOOKUP, rand64(), rand64());
        queue_req(REQ_NOP, rand64(), rand64());
        queue_req(REQ_REGISTER, {32{2'b01}}, {32{2'b10}});
        queue_req(REQ_REGISTER, {32{2'b10}}, {32{2'b01}});
        queue_req(REQ_LOOKUP, {32{2'b10}}, '0);
        queue_req(REQ_CLEAR, rand64(), rand64());
        queue_req(REQ_LOOKUP, '0, rand64());
        queue_req(REQ_REGISTER, {32{2'b10}}, '0);
        queue_req(REQ_LOOKUP, {32{2'b10}}, '1);
        queue_req(REQ_NOP, '1, {1'b1, {(VAL_W - 1){1'b0}}});
        queue_req(REQ_CLEAR, '0, '0);
        queue_req(REQ_CLEAR, '1, '1);
        queue_req(REQ_REGISTER, 64'd1, 64'sd1);

        // random part
        mixed_burst(180);
        fill_to_capacity();
        mixed_burst(300);
        fill_to_capacity();
        mixed_burst(390);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (req_backlog.size() != 0)
            @(posedge clk);
        while (result_due.size() != 0)
            @(posedge clk);
        // quiet period to catch any stray done
        repeat (TABLE_DEPTH + 8) @(posedge clk);

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
